FILE: src/dual_device_update_reset_sync_top_defines.svh
// Assertion macros shared by the update/reset coordinator RTL.
`ifndef DUAL_DEVICE_UPDATE_RESET_SYNC_TOP_DEFINES_SVH
`define DUAL_DEVICE_UPDATE_RESET_SYNC_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, idle during reset.
`define DDURS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddurs assertion failed");

// Next-cycle implication, checked on clk, idle during reset.
`define DDURS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddurs assertion failed");

`endif

FILE: src/ddurs_pkg.sv
// Types and constants for the update/reset coordinator.
`timescale 1ns / 1ps
package ddurs_pkg;

    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_PROGRESS = 3'd1;
    localparam logic [2:0] CMD_MARK_RDY = 3'd2;
    localparam logic [2:0] CMD_RST_NOW  = 3'd3;
    localparam logic [2:0] CMD_PEER     = 3'd4;
    localparam logic [2:0] CMD_ABORT    = 3'd5;
    localparam logic [2:0] CMD_TICK     = 3'd6;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_DOWNLOAD = 3'd1;
    localparam logic [2:0] PH_VALIDATE = 3'd2;
    localparam logic [2:0] PH_WAITING  = 3'd3;
    localparam logic [2:0] PH_READY    = 3'd4;
    localparam logic [2:0] PH_ERROR    = 3'd5;

    localparam logic [1:0] ROLE_PRI  = 2'd0;
    localparam logic [1:0] ROLE_SEC  = 2'd1;
    localparam logic [1:0] ROLE_BOTH = 2'd2;

    localparam logic [1:0] RET_OK      = 2'd0;
    localparam logic [1:0] RET_BUSY    = 2'd1;
    localparam logic [1:0] RET_INVALID = 2'd2;

    localparam logic [1:0] REG_PEER_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_RESET_DELAY  = 2'd1;
    localparam logic [1:0] REG_MAX_WAIT     = 2'd2;

    localparam logic [23:0] PEER_TIMEOUT_RST = 24'd30000;
    localparam logic [23:0] RESET_DELAY_RST  = 24'd1000;
    localparam logic [23:0] MAX_WAIT_RST     = 24'd60000;

    localparam logic [7:0] PCT_DONE = 8'd100;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  role;
        logic [31:0] img_size;
        logic [7:0]  percent;
        logic [31:0] byte_count;
        logic        peer_says_ready;
    } item_t;

    // State after one command, handed to the result stage
    typedef struct packed {
        logic [1:0]  ret_code;
        logic [2:0]  phase;
        logic [1:0]  target;
        logic [7:0]  prog0;
        logic [7:0]  prog1;
        logic [31:0] bytes0;
        logic [31:0] bytes1;
        logic [31:0] total0;
        logic [31:0] total1;
        logic        rdy0;
        logic        rdy1;
        logic        pulse;
    } snap_t;

endpackage

FILE: src/ddurs_core.sv
// Input register, configuration registers and command state update.
`timescale 1ns / 1ps
`include "dual_device_update_reset_sync_top_defines.svh"
module ddurs_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ddurs_pkg::item_t     item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 load_ok,
    output logic                 advance,
    output ddurs_pkg::snap_t     snap
);

    logic              inv_reg;
    ddurs_pkg::item_t  item_reg;

    logic [23:0] peer_to_reg;
    logic [23:0] rst_delay_reg;
    logic [23:0] max_wait_reg;

    logic [2:0]        phase_reg,  phase_next;
    logic [1:0]        target_reg, target_next;
    logic [1:0][7:0]   prog_reg,   prog_next;
    logic [1:0][31:0]  bytes_reg,  bytes_next;
    logic [1:0][31:0]  total_reg,  total_next;
    logic [1:0]        rdy_reg,    rdy_next;
    logic [1:0][31:0]  rtime_reg,  rtime_next;
    logic [31:0]       uptime_reg, uptime_next;
    logic [23:0]       ptl_reg,    ptl_next;
    logic              pta_reg,    pta_next;
    logic [23:0]       rtl_reg,    rtl_next;
    logic              rta_reg,    rta_next;
    logic [1:0]        ret;
    logic              pulse;

    assign in_ready = !inv_reg || load_ok;
    assign advance  = inv_reg && load_ok;

    always_comb
    begin
        logic        pd;
        logic        sd;
        logic [31:0] since;
        logic [31:0] wait_ms;

        phase_next  = phase_reg;
        target_next = target_reg;
        prog_next   = prog_reg;
        bytes_next  = bytes_reg;
        total_next  = total_reg;
        rdy_next    = rdy_reg;
        rtime_next  = rtime_reg;
        uptime_next = uptime_reg;
        ptl_next    = ptl_reg;
        pta_next    = pta_reg;
        rtl_next    = rtl_reg;
        rta_next    = rta_reg;
        ret         = ddurs_pkg::RET_OK;
        pulse       = 1'b0;
        pd          = 1'b0;
        sd          = 1'b0;
        since       = '0;
        wait_ms     = '0;

        case (item_reg.cmd)
            ddurs_pkg::CMD_START:
            begin
                if (phase_reg != ddurs_pkg::PH_IDLE)
                begin
                    ret = ddurs_pkg::RET_BUSY;
                end
                else if (item_reg.role > ddurs_pkg::ROLE_BOTH)
                begin
                    ret = ddurs_pkg::RET_INVALID;
                end
                else
                begin
                    prog_next   = '0;
                    bytes_next  = '0;
                    total_next  = '0;
                    rdy_next    = '0;
                    rtime_next  = '0;
                    target_next = item_reg.role;
                    phase_next  = ddurs_pkg::PH_DOWNLOAD;
                    if (item_reg.role != ddurs_pkg::ROLE_SEC)
                        total_next[0] = item_reg.img_size;
                    if (item_reg.role != ddurs_pkg::ROLE_PRI)
                        total_next[1] = item_reg.img_size;
                end
            end
            ddurs_pkg::CMD_PROGRESS:
            begin
                if (phase_reg != ddurs_pkg::PH_DOWNLOAD)
                begin
                    ret = ddurs_pkg::RET_INVALID;
                end
                else
                begin
                    if (!item_reg.role[1])
                    begin
                        prog_next[item_reg.role[0]]  = item_reg.percent;
                        bytes_next[item_reg.role[0]] = item_reg.byte_count;
                    end
                    pd = (target_reg == ddurs_pkg::ROLE_SEC) ||
                         (prog_next[0] >= ddurs_pkg::PCT_DONE);
                    sd = (target_reg == ddurs_pkg::ROLE_PRI) ||
                         (prog_next[1] >= ddurs_pkg::PCT_DONE);
                    if (pd && sd)
                        phase_next = ddurs_pkg::PH_VALIDATE;
                end
            end
            ddurs_pkg::CMD_MARK_RDY:
            begin
                if (phase_reg != ddurs_pkg::PH_VALIDATE &&
                    phase_reg != ddurs_pkg::PH_WAITING)
                begin
                    ret = ddurs_pkg::RET_INVALID;
                end
                else
                begin
                    if (!item_reg.role[1])
                    begin
                        rdy_next[item_reg.role[0]]   = 1'b1;
                        rtime_next[item_reg.role[0]] = uptime_reg;
                    end
                    if (target_reg == ddurs_pkg::ROLE_BOTH && !(rdy_next[0] && rdy_next[1]))
                    begin
                        phase_next = ddurs_pkg::PH_WAITING;
                        if (!pta_reg)
                        begin
                            pta_next = 1'b1;
                            ptl_next = peer_to_reg;
                        end
                    end
                    else
                    begin
                        phase_next = ddurs_pkg::PH_READY;
                        if (!rta_reg)
                        begin
                            rta_next = 1'b1;
                            rtl_next = rst_delay_reg;
                        end
                    end
                end
            end
            ddurs_pkg::CMD_RST_NOW:
            begin
                if (phase_reg != ddurs_pkg::PH_READY)
                begin
                    ret = ddurs_pkg::RET_INVALID;
                end
                else if (!rta_reg)
                begin
                    rta_next = 1'b1;
                    rtl_next = rst_delay_reg;
                end
            end
            ddurs_pkg::CMD_PEER:
            begin
                if (item_reg.peer_says_ready)
                begin
                    rdy_next[1]   = 1'b1;
                    rtime_next[1] = uptime_reg;
                    if (phase_reg == ddurs_pkg::PH_WAITING && rdy_reg[0])
                    begin
                        phase_next = ddurs_pkg::PH_READY;
                        pta_next   = 1'b0;
                        ptl_next   = '0;
                        if (!rta_reg)
                        begin
                            rta_next = 1'b1;
                            rtl_next = rst_delay_reg;
                        end
                    end
                end
            end
            ddurs_pkg::CMD_ABORT:
            begin
                pta_next   = 1'b0;
                ptl_next   = '0;
                rta_next   = 1'b0;
                rtl_next   = '0;
                phase_next = ddurs_pkg::PH_IDLE;
                prog_next  = '0;
                bytes_next = '0;
                total_next = '0;
                rdy_next   = '0;
                rtime_next = '0;
            end
            ddurs_pkg::CMD_TICK:
            begin
                uptime_next = uptime_reg + 32'd1;
                if (rta_reg && rtl_reg <= 24'd1)
                begin
                    // reset issued: everything but the registers goes back
                    phase_next  = ddurs_pkg::PH_IDLE;
                    target_next = ddurs_pkg::ROLE_PRI;
                    prog_next   = '0;
                    bytes_next  = '0;
                    total_next  = '0;
                    rdy_next    = '0;
                    rtime_next  = '0;
                    uptime_next = '0;
                    ptl_next    = '0;
                    pta_next    = 1'b0;
                    rtl_next    = '0;
                    rta_next    = 1'b0;
                    pulse       = 1'b1;
                end
                else
                begin
                    if (rta_reg)
                        rtl_next = rtl_reg - 24'd1;
                    if (pta_reg && ptl_reg > 24'd1)
                    begin
                        ptl_next = ptl_reg - 24'd1;
                    end
                    else if (pta_reg)
                    begin
                        ptl_next = '0;
                        pta_next = 1'b0;
                        if (phase_reg == ddurs_pkg::PH_WAITING)
                        begin
                            since   = rdy_reg[0] ? rtime_reg[0] : rtime_reg[1];
                            wait_ms = uptime_next - since;
                            if (wait_ms > {8'd0, max_wait_reg})
                            begin
                                phase_next = ddurs_pkg::PH_ERROR;
                            end
                            else
                            begin
                                phase_next = ddurs_pkg::PH_READY;
                                // an armed reset countdown keeps running
                                if (!rta_reg)
                                begin
                                    rta_next = 1'b1;
                                    rtl_next = rst_delay_reg;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                ret = ddurs_pkg::RET_INVALID;
            end
        endcase
    end

    assign snap.ret_code = ret;
    assign snap.phase    = phase_next;
    assign snap.target   = target_next;
    assign snap.prog0    = prog_next[0];
    assign snap.prog1    = prog_next[1];
    assign snap.bytes0   = bytes_next[0];
    assign snap.bytes1   = bytes_next[1];
    assign snap.total0   = total_next[0];
    assign snap.total1   = total_next[1];
    assign snap.rdy0     = rdy_next[0];
    assign snap.rdy1     = rdy_next[1];
    assign snap.pulse    = pulse;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg       <= 1'b0;
            peer_to_reg   <= ddurs_pkg::PEER_TIMEOUT_RST;
            rst_delay_reg <= ddurs_pkg::RESET_DELAY_RST;
            max_wait_reg  <= ddurs_pkg::MAX_WAIT_RST;
            phase_reg     <= ddurs_pkg::PH_IDLE;
            target_reg    <= ddurs_pkg::ROLE_PRI;
            prog_reg      <= '0;
            bytes_reg     <= '0;
            total_reg     <= '0;
            rdy_reg       <= '0;
            rtime_reg     <= '0;
            uptime_reg    <= '0;
            ptl_reg       <= '0;
            pta_reg       <= 1'b0;
            rtl_reg       <= '0;
            rta_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
                inv_reg <= in_valid;
            if (cfg_we)
            begin
                case (cfg_index)
                    ddurs_pkg::REG_PEER_TIMEOUT: peer_to_reg   <= cfg_data;
                    ddurs_pkg::REG_RESET_DELAY:  rst_delay_reg <= cfg_data;
                    ddurs_pkg::REG_MAX_WAIT:     max_wait_reg  <= cfg_data;
                    default:                     ;
                endcase
            end
            if (advance)
            begin
                phase_reg  <= phase_next;
                target_reg <= target_next;
                prog_reg   <= prog_next;
                bytes_reg  <= bytes_next;
                total_reg  <= total_next;
                rdy_reg    <= rdy_next;
                rtime_reg  <= rtime_next;
                uptime_reg <= uptime_next;
                ptl_reg    <= ptl_next;
                pta_reg    <= pta_next;
                rtl_reg    <= rtl_next;
                rta_reg    <= rta_next;
            end
        end
    end

    `DDURS_ASSERT_IMPL(a_peer_idle_zero, !pta_reg, ptl_reg == 24'd0)
    `DDURS_ASSERT_IMPL(a_rst_idle_zero, !rta_reg, rtl_reg == 24'd0)
    `DDURS_ASSERT_NEXT(a_tick_uptime,
        advance && item_reg.cmd == ddurs_pkg::CMD_TICK && !pulse,
        uptime_reg == $past(uptime_reg) + 32'd1)

endmodule

FILE: src/ddurs_out.sv
// Result stage: status snapshot reduction and output register.
`timescale 1ns / 1ps
`include "dual_device_update_reset_sync_top_defines.svh"
module ddurs_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ddurs_pkg::snap_t  snap,
    output logic              load_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        ret_code,
    output logic [2:0]        sync_state,
    output logic [1:0]        target_now,
    output logic [7:0]        progress_out,
    output logic [32:0]       bytes_out,
    output logic [32:0]       total_out,
    output logic              primary_ready,
    output logic              secondary_ready,
    output logic              all_ready,
    output logic              reset_request
);

    logic        out_valid_reg;
    logic [1:0]  ret_reg;
    logic [2:0]  state_reg;
    logic [1:0]  target_reg;
    logic [7:0]  prog_reg,  prog_next;
    logic [32:0] bytes_reg, bytes_next;
    logic [32:0] total_reg, total_next;
    logic        prdy_reg;
    logic        srdy_reg;
    logic        all_reg,   all_next;
    logic        pulse_reg;
    logic [8:0]  prog_sum;

    assign load_ok  = !out_valid_reg || out_ready;
    assign prog_sum = {1'b0, snap.prog0} + {1'b0, snap.prog1};

    always_comb
    begin
        if (snap.target == ddurs_pkg::ROLE_BOTH)
        begin
            prog_next  = prog_sum[8:1];
            bytes_next = {1'b0, snap.bytes0} + {1'b0, snap.bytes1};
            total_next = {1'b0, snap.total0} + {1'b0, snap.total1};
        end
        else if (snap.target == ddurs_pkg::ROLE_PRI)
        begin
            prog_next  = snap.prog0;
            bytes_next = {1'b0, snap.bytes0};
            total_next = {1'b0, snap.total0};
        end
        else
        begin
            prog_next  = snap.prog1;
            bytes_next = {1'b0, snap.bytes1};
            total_next = {1'b0, snap.total1};
        end
        all_next = (snap.target != ddurs_pkg::ROLE_BOTH) || (snap.rdy0 && snap.rdy1);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ret_reg    <= snap.ret_code;
            state_reg  <= snap.phase;
            target_reg <= snap.target;
            prog_reg   <= prog_next;
            bytes_reg  <= bytes_next;
            total_reg  <= total_next;
            prdy_reg   <= snap.rdy0;
            srdy_reg   <= snap.rdy1;
            all_reg    <= all_next;
            pulse_reg  <= snap.pulse;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_ok)
            out_valid_reg <= advance;
    end

    assign out_valid       = out_valid_reg;
    assign ret_code        = ret_reg;
    assign sync_state      = state_reg;
    assign target_now      = target_reg;
    assign progress_out    = prog_reg;
    assign bytes_out       = bytes_reg;
    assign total_out       = total_reg;
    assign primary_ready   = prdy_reg;
    assign secondary_ready = srdy_reg;
    assign all_ready       = all_reg;
    assign reset_request   = pulse_reg;

    // a reset pulse always shows the cleared record
    `DDURS_ASSERT_IMPL(a_pulse_clean, out_valid_reg && pulse_reg,
        state_reg == ddurs_pkg::PH_IDLE && target_reg == ddurs_pkg::ROLE_PRI &&
        !prdy_reg && !srdy_reg && ret_reg == ddurs_pkg::RET_OK)

endmodule

FILE: src/dual_device_update_reset_sync_top.sv
// Top level of the dual-device update and reset coordinator.
// Path: input register, then a single-pass state update, then the output register.
// Throughput: one command per cycle unless out_ready holds the result back.
// Reset (rst_n low, async): phase idle, target primary, device records and countdowns
// cleared, configuration back to 30000 / 1000 / 60000 ms; no clearing pass.
`timescale 1ns / 1ps
module dual_device_update_reset_sync_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [1:0]  role,
    input  logic [31:0] img_size,
    input  logic [7:0]  percent,
    input  logic [31:0] byte_count,
    input  logic        peer_says_ready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  ret_code,
    output logic [2:0]  sync_state,
    output logic [1:0]  target_now,
    output logic [7:0]  progress_out,
    output logic [32:0] bytes_out,
    output logic [32:0] total_out,
    output logic        primary_ready,
    output logic        secondary_ready,
    output logic        all_ready,
    output logic        reset_request
);

    ddurs_pkg::item_t item;
    ddurs_pkg::snap_t snap;
    logic             load_ok;
    logic             advance;

    assign item.cmd             = cmd;
    assign item.role            = role;
    assign item.img_size        = img_size;
    assign item.percent         = percent;
    assign item.byte_count      = byte_count;
    assign item.peer_says_ready = peer_says_ready;

    ddurs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load_ok   (load_ok),
        .advance   (advance),
        .snap      (snap)
    );

    ddurs_out u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .snap            (snap),
        .load_ok         (load_ok),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ret_code        (ret_code),
        .sync_state      (sync_state),
        .target_now      (target_now),
        .progress_out    (progress_out),
        .bytes_out       (bytes_out),
        .total_out       (total_out),
        .primary_ready   (primary_ready),
        .secondary_ready (secondary_ready),
        .all_ready       (all_ready),
        .reset_request   (reset_request)
    );

endmodule

FILE: tb/sv/dual_device_update_reset_sync_top_test.sv
// Self-checking testbench for the dual-device update and reset coordinator.
`timescale 1ns / 1ps
module dual_device_update_reset_sync_top_test;

    // Field values outside the defined codes, still legal on the ports
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [1:0] ROLE_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  ret;
        logic [2:0]  phase;
        logic [1:0]  target;
        logic [7:0]  prog;
        logic [32:0] rx_bytes;
        logic [32:0] total;
        logic        pri_rdy;
        logic        sec_rdy;
        logic        all_rdy;
        logic        rst_req;
    } status_t;

    // Tracks the coordinator state and holds the status each command should produce.
    class sync_scoreboard;
        logic [23:0] peer_timeout;
        logic [23:0] reset_delay;
        logic [23:0] max_wait;
        logic [2:0]  phase;
        logic [1:0]  target;
        logic [7:0]  pct [2];
        logic [31:0] rx_bytes [2];
        logic [31:0] image_total [2];
        logic        ready_flag [2];
        logic [31:0] ready_at [2];
        logic [31:0] uptime;
        logic [23:0] peer_left;
        logic [23:0] reset_left;
        logic        peer_armed;
        logic        reset_armed;
        status_t     expected_status [$];
        int          errors;
        int          checked;
        int          pulses;
        int          cmd_count [8];

        function new();
            errors  = 0;
            checked = 0;
            pulses  = 0;
            foreach (cmd_count[i])
                cmd_count[i] = 0;
            peer_timeout = ddurs_pkg::PEER_TIMEOUT_RST;
            reset_delay  = ddurs_pkg::RESET_DELAY_RST;
            max_wait     = ddurs_pkg::MAX_WAIT_RST;
            clear_all();
        endfunction

        function void clear_devices();
            for (int i = 0; i < 2; i++)
            begin
                pct[i]         = '0;
                rx_bytes[i]    = '0;
                image_total[i] = '0;
                ready_flag[i]  = 1'b0;
                ready_at[i]    = '0;
            end
        endfunction

        function void clear_all();
            phase       = ddurs_pkg::PH_IDLE;
            target      = ddurs_pkg::ROLE_PRI;
            clear_devices();
            uptime      = '0;
            peer_left   = '0;
            peer_armed  = 1'b0;
            reset_left  = '0;
            reset_armed = 1'b0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            case (idx)
                ddurs_pkg::REG_PEER_TIMEOUT: peer_timeout = val;
                ddurs_pkg::REG_RESET_DELAY:  reset_delay  = val;
                ddurs_pkg::REG_MAX_WAIT:     max_wait     = val;
                default: ;
            endcase
        endfunction

        // A running countdown is never restarted
        function void arm_reset();
            if (!reset_armed)
            begin
                reset_armed = 1'b1;
                reset_left  = reset_delay;
            end
        endfunction

        function void arm_peer();
            if (!peer_armed)
            begin
                peer_armed = 1'b1;
                peer_left  = peer_timeout;
            end
        endfunction

        function void peer_expired();
            logic [31:0] since;
            logic [31:0] waited;
            if (phase == ddurs_pkg::PH_WAITING)
            begin
                since  = ready_flag[0] ? ready_at[0] : ready_at[1];
                waited = uptime - since;
                if (waited > {8'd0, max_wait})
                    phase = ddurs_pkg::PH_ERROR;
                else
                begin
                    phase = ddurs_pkg::PH_READY;
                    arm_reset();
                end
            end
        endfunction

        function void note(ddurs_pkg::item_t it);
            status_t     s;
            logic        pulse;
            logic        pri_done;
            logic        sec_done;
            logic [8:0]  psum;
            int          d;
            s.ret = ddurs_pkg::RET_OK;
            pulse = 1'b0;
            cmd_count[it.cmd]++;
            case (it.cmd)
                ddurs_pkg::CMD_START:
                    if (phase != ddurs_pkg::PH_IDLE)
                        s.ret = ddurs_pkg::RET_BUSY;
                    else if (it.role > ddurs_pkg::ROLE_BOTH)
                        s.ret = ddurs_pkg::RET_INVALID;
                    else
                    begin
                        clear_devices();
                        target = it.role;
                        phase  = ddurs_pkg::PH_DOWNLOAD;
                        if (it.role == ddurs_pkg::ROLE_PRI || it.role == ddurs_pkg::ROLE_BOTH)
                            image_total[0] = it.img_size;
                        if (it.role == ddurs_pkg::ROLE_SEC || it.role == ddurs_pkg::ROLE_BOTH)
                            image_total[1] = it.img_size;
                    end
                ddurs_pkg::CMD_PROGRESS:
                    if (phase != ddurs_pkg::PH_DOWNLOAD)
                        s.ret = ddurs_pkg::RET_INVALID;
                    else
                    begin
                        if (it.role == ddurs_pkg::ROLE_PRI || it.role == ddurs_pkg::ROLE_SEC)
                        begin
                            pct[it.role[0]]      = it.percent;
                            rx_bytes[it.role[0]] = it.byte_count;
                        end
                        pri_done = (target == ddurs_pkg::ROLE_SEC) ||
                                   (pct[0] >= ddurs_pkg::PCT_DONE);
                        sec_done = (target == ddurs_pkg::ROLE_PRI) ||
                                   (pct[1] >= ddurs_pkg::PCT_DONE);
                        if (pri_done && sec_done)
                            phase = ddurs_pkg::PH_VALIDATE;
                    end
                ddurs_pkg::CMD_MARK_RDY:
                    if (phase != ddurs_pkg::PH_VALIDATE && phase != ddurs_pkg::PH_WAITING)
                        s.ret = ddurs_pkg::RET_INVALID;
                    else
                    begin
                        if (it.role == ddurs_pkg::ROLE_PRI || it.role == ddurs_pkg::ROLE_SEC)
                        begin
                            ready_flag[it.role[0]] = 1'b1;
                            ready_at[it.role[0]]   = uptime;
                        end
                        if (target == ddurs_pkg::ROLE_BOTH &&
                            !(ready_flag[0] && ready_flag[1]))
                        begin
                            phase = ddurs_pkg::PH_WAITING;
                            arm_peer();
                        end
                        else
                        begin
                            phase = ddurs_pkg::PH_READY;
                            arm_reset();
                        end
                    end
                ddurs_pkg::CMD_RST_NOW:
                    if (phase != ddurs_pkg::PH_READY)
                        s.ret = ddurs_pkg::RET_INVALID;
                    else
                        arm_reset();
                ddurs_pkg::CMD_PEER:
                    if (it.peer_says_ready)
                    begin
                        ready_flag[1] = 1'b1;
                        ready_at[1]   = uptime;
                        if (phase == ddurs_pkg::PH_WAITING && ready_flag[0])
                        begin
                            phase      = ddurs_pkg::PH_READY;
                            peer_armed = 1'b0;
                            peer_left  = '0;
                            arm_reset();
                        end
                    end
                ddurs_pkg::CMD_ABORT:
                begin
                    peer_armed  = 1'b0;
                    peer_left   = '0;
                    reset_armed = 1'b0;
                    reset_left  = '0;
                    phase       = ddurs_pkg::PH_IDLE;
                    clear_devices();
                end
                ddurs_pkg::CMD_TICK:
                begin
                    uptime = uptime + 32'd1;
                    // reset countdown first; the peer countdown only runs if it did not fire
                    if (reset_armed && reset_left <= 24'd1)
                    begin
                        clear_all();
                        pulse = 1'b1;
                        pulses++;
                    end
                    else
                    begin
                        if (reset_armed)
                            reset_left = reset_left - 24'd1;
                        if (peer_armed && peer_left <= 24'd1)
                        begin
                            peer_armed = 1'b0;
                            peer_left  = '0;
                            peer_expired();
                        end
                        else if (peer_armed)
                            peer_left = peer_left - 24'd1;
                    end
                end
                default: s.ret = ddurs_pkg::RET_INVALID;
            endcase

            if (target == ddurs_pkg::ROLE_BOTH)
            begin
                psum       = {1'b0, pct[0]} + {1'b0, pct[1]};
                s.prog     = psum[8:1];
                s.rx_bytes = {1'b0, rx_bytes[0]} + {1'b0, rx_bytes[1]};
                s.total    = {1'b0, image_total[0]} + {1'b0, image_total[1]};
            end
            else
            begin
                d          = (target == ddurs_pkg::ROLE_PRI) ? 0 : 1;
                s.prog     = pct[d];
                s.rx_bytes = {1'b0, rx_bytes[d]};
                s.total    = {1'b0, image_total[d]};
            end
            s.phase   = phase;
            s.target  = target;
            s.pri_rdy = ready_flag[0];
            s.sec_rdy = ready_flag[1];
            s.all_rdy = (target != ddurs_pkg::ROLE_BOTH) || (ready_flag[0] && ready_flag[1]);
            s.rst_req = pulse;
            expected_status.push_back(s);
        endfunction

        function void compare(string name, logic [32:0] want, logic [32:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check(status_t got);
            status_t want;
            if (expected_status.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                errors++;
                return;
            end
            want = expected_status.pop_front();
            checked++;
            compare("ret_code",        want.ret,      got.ret);
            compare("sync_state",      want.phase,    got.phase);
            compare("target_now",      want.target,   got.target);
            compare("progress_out",    want.prog,     got.prog);
            compare("bytes_out",       want.rx_bytes, got.rx_bytes);
            compare("total_out",       want.total,    got.total);
            compare("primary_ready",   want.pri_rdy,  got.pri_rdy);
            compare("secondary_ready", want.sec_rdy,  got.sec_rdy);
            compare("all_ready",       want.all_rdy,  got.all_rdy);
            compare("reset_request",   want.rst_req,  got.rst_req);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [1:0]  role;
    logic [31:0] img_size;
    logic [7:0]  percent;
    logic [31:0] byte_count;
    logic        peer_says_ready;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  ret_code;
    logic [2:0]  sync_state;
    logic [1:0]  target_now;
    logic [7:0]  progress_out;
    logic [32:0] bytes_out;
    logic [32:0] total_out;
    logic        primary_ready;
    logic        secondary_ready;
    logic        all_ready;
    logic        reset_request;

    sync_scoreboard sb;
    bit             steady_flow = 1'b0;
    bit             hold_req = 1'b0;
    int             sent = 0;
    int             settings_used = 0;

    dual_device_update_reset_sync_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .role            (role),
        .img_size        (img_size),
        .percent         (percent),
        .byte_count      (byte_count),
        .peer_says_ready (peer_says_ready),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ret_code        (ret_code),
        .sync_state      (sync_state),
        .target_now      (target_now),
        .progress_out    (progress_out),
        .bytes_out       (bytes_out),
        .total_out       (total_out),
        .primary_ready   (primary_ready),
        .secondary_ready (secondary_ready),
        .all_ready       (all_ready),
        .reset_request   (reset_request)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #(1_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random back-pressure except in steady flow, one long hold on request
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                hold_left = 200;
                held      = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (steady_flow)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check(status_t'({ret_code, sync_state, target_now, progress_out, bytes_out,
                                total_out, primary_ready, secondary_ready, all_ready,
                                reset_request}));
    end

    function automatic ddurs_pkg::item_t mk(logic [2:0] c, logic [1:0] r, logic [31:0] size,
                                            logic [7:0] p, logic [31:0] cnt, logic peer);
        ddurs_pkg::item_t it;
        it.cmd             = c;
        it.role            = r;
        it.img_size        = size;
        it.percent         = p;
        it.byte_count      = cnt;
        it.peer_says_ready = peer;
        return it;
    endfunction

    function automatic logic [31:0] wide_value();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly addresses the device the update is aimed at
    function automatic logic [1:0] device_role();
        if ($urandom_range(0, 99) >= 85)
            return 2'($urandom_range(0, 3));
        if (sb.target == ddurs_pkg::ROLE_BOTH)
            return $urandom_range(0, 1) ? ddurs_pkg::ROLE_SEC : ddurs_pkg::ROLE_PRI;
        return sb.target;
    endfunction

    // Picks the next command from the predicted phase so sequences run to completion
    function automatic ddurs_pkg::item_t next_command();
        ddurs_pkg::item_t it;
        int               r;
        it.cmd             = ddurs_pkg::CMD_TICK;
        it.role            = 2'($urandom_range(0, 3));
        it.img_size        = wide_value();
        it.byte_count      = wide_value();
        it.peer_says_ready = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0:       it.percent = ddurs_pkg::PCT_DONE;
            1:       it.percent = ddurs_pkg::PCT_DONE - 8'd1;
            2:       it.percent = 8'($urandom_range(100, 255));
            default: it.percent = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 99) < 8)
        begin
            it.cmd = 3'($urandom_range(0, 7));
            return it;
        end
        r = $urandom_range(0, 99);
        case (sb.phase)
            ddurs_pkg::PH_IDLE:
                if (r < 60)
                begin
                    it.cmd  = ddurs_pkg::CMD_START;
                    it.role = (r < 5) ? ROLE_NONE : 2'($urandom_range(0, 2));
                end
                else if (r < 80)
                    it.cmd = ddurs_pkg::CMD_PEER;
                else
                    it.cmd = ddurs_pkg::CMD_TICK;
            ddurs_pkg::PH_DOWNLOAD:
                if (r < 70)
                begin
                    it.cmd  = ddurs_pkg::CMD_PROGRESS;
                    it.role = device_role();
                end
                else if (r < 85)
                    it.cmd = ddurs_pkg::CMD_TICK;
                else if (r < 90)
                    it.cmd = ddurs_pkg::CMD_START;
                else if (r < 93)
                    it.cmd = ddurs_pkg::CMD_ABORT;
                else
                    it.cmd = ddurs_pkg::CMD_PEER;
            ddurs_pkg::PH_VALIDATE:
                if (r < 55)
                begin
                    it.cmd  = ddurs_pkg::CMD_MARK_RDY;
                    it.role = device_role();
                end
                else if (r < 75)
                    it.cmd = ddurs_pkg::CMD_TICK;
                else if (r < 85)
                    it.cmd = ddurs_pkg::CMD_PEER;
                else if (r < 90)
                    it.cmd = ddurs_pkg::CMD_RST_NOW;
                else if (r < 93)
                    it.cmd = ddurs_pkg::CMD_ABORT;
                else
                    it.cmd = ddurs_pkg::CMD_PROGRESS;
            ddurs_pkg::PH_WAITING:
                if (r < 45)
                    it.cmd = ddurs_pkg::CMD_TICK;
                else if (r < 70)
                begin
                    it.cmd             = ddurs_pkg::CMD_PEER;
                    it.peer_says_ready = ($urandom_range(0, 9) < 7);
                end
                else if (r < 92)
                begin
                    it.cmd  = ddurs_pkg::CMD_MARK_RDY;
                    it.role = device_role();
                end
                else
                    it.cmd = ddurs_pkg::CMD_ABORT;
            ddurs_pkg::PH_READY:
                if (r < 70)
                    it.cmd = ddurs_pkg::CMD_TICK;
                else if (r < 85)
                    it.cmd = ddurs_pkg::CMD_RST_NOW;
                else if (r < 92)
                    it.cmd = ddurs_pkg::CMD_PEER;
                else
                    it.cmd = ddurs_pkg::CMD_ABORT;
            default:
                if (r < 40)
                    it.cmd = ddurs_pkg::CMD_ABORT;
                else if (r < 75)
                    it.cmd = ddurs_pkg::CMD_TICK;
                else if (r < 88)
                    it.cmd = ddurs_pkg::CMD_START;
                else
                    it.cmd = ddurs_pkg::CMD_MARK_RDY;
        endcase
        return it;
    endfunction

    task automatic send_item(input ddurs_pkg::item_t it);
        if (!steady_flow && $urandom_range(0, 99) < 8)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        cmd             <= it.cmd;
        role            <= it.role;
        img_size        <= it.img_size;
        percent         <= it.percent;
        byte_count      <= it.byte_count;
        peer_says_ready <= it.peer_says_ready;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note(it);
        sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    // Registers change only with nothing in flight
    task automatic program_regs(input logic [23:0] peer_to, input logic [23:0] delay,
                                input logic [23:0] max_w);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_reg(ddurs_pkg::REG_PEER_TIMEOUT, peer_to);
        write_reg(ddurs_pkg::REG_RESET_DELAY, delay);
        write_reg(ddurs_pkg::REG_MAX_WAIT, max_w);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            steady_flow = (sent >= 80 && sent < 230);
            if (sent == 300)
                hold_req = 1'b1;
            send_item(next_command());
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        cmd             = ddurs_pkg::CMD_START;
        role            = ddurs_pkg::ROLE_PRI;
        img_size        = '0;
        percent         = '0;
        byte_count      = '0;
        peer_says_ready = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = ddurs_pkg::REG_PEER_TIMEOUT;
        cfg_data        = '0;
        sb = new();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // short peer timeout, zero reset delay (acts as one tick), tight wait limit
        program_regs(24'd3, 24'd0, 24'd1);
        send_item(mk(CMD_UNUSED, ROLE_NONE, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PROGRESS, ddurs_pkg::ROLE_PRI, 32'd0,
                     ddurs_pkg::PCT_DONE, 32'd5, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PEER, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b1));
        send_item(mk(ddurs_pkg::CMD_START, ROLE_NONE, 32'd1, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_START, ddurs_pkg::ROLE_BOTH, 32'hFFFF_FFFF,
                     8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_START, ddurs_pkg::ROLE_PRI, 32'd5, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PROGRESS, ddurs_pkg::ROLE_PRI, 32'd0,
                     8'd255, 32'hFFFF_FFFF, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PROGRESS, ROLE_NONE, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PROGRESS, ddurs_pkg::ROLE_SEC, 32'd0,
                     ddurs_pkg::PCT_DONE, 32'hFFFF_FFFF, 1'b0));
        send_item(mk(ddurs_pkg::CMD_RST_NOW, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_MARK_RDY, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b0));
        // peer countdown runs out with the wait above the limit
        repeat (3)
            send_item(mk(ddurs_pkg::CMD_TICK, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_ABORT, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_START, ddurs_pkg::ROLE_BOTH, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PROGRESS, ddurs_pkg::ROLE_PRI, 32'd0,
                     ddurs_pkg::PCT_DONE, 32'd7, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PROGRESS, ddurs_pkg::ROLE_SEC, 32'd0,
                     8'd99, 32'd9, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PROGRESS, ddurs_pkg::ROLE_SEC, 32'd0,
                     ddurs_pkg::PCT_DONE, 32'd11, 1'b0));
        send_item(mk(ddurs_pkg::CMD_MARK_RDY, ddurs_pkg::ROLE_BOTH, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_MARK_RDY, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PEER, ddurs_pkg::ROLE_SEC, 32'd0, 8'd0, 32'd0, 1'b1));
        send_item(mk(ddurs_pkg::CMD_RST_NOW, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_TICK, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_START, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_PROGRESS, ddurs_pkg::ROLE_PRI, 32'd0,
                     ddurs_pkg::PCT_DONE, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_MARK_RDY, ddurs_pkg::ROLE_BOTH, 32'd0, 8'd0, 32'd0, 1'b0));
        send_item(mk(ddurs_pkg::CMD_ABORT, ddurs_pkg::ROLE_PRI, 32'd0, 8'd0, 32'd0, 1'b0));

        program_regs(24'd5, 24'd3, 24'd4);
        send_random(500);
        program_regs(24'd1, 24'd1, 24'd0);
        send_random(300);
        program_regs(24'd0, 24'd0, 24'hFF_FFFF);
        send_random(300);
        // countdowns that never run out within the run
        program_regs(24'hFF_FFFF, 24'hFF_FFFF, 24'($urandom_range(0, 20)));
        send_random(150);
        program_regs(24'($urandom_range(1, 12)), 24'($urandom_range(1, 12)),
                     24'($urandom_range(0, 20)));
        send_random(450);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d commands over %0d register settings: %0d starts, %0d ticks,",
                 sent, settings_used, sb.cmd_count[ddurs_pkg::CMD_START],
                 sb.cmd_count[ddurs_pkg::CMD_TICK]);
        $display("%0d resets issued; compared %0d status results field by field, %0d mismatches.",
                 sb.pulses, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
